/* hdl/isa_pkg.sv */
package isa_pkg;

   // list geometry
   localparam int DEPTH  = 16;
   localparam int ELEM_W = 32;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int OP_W   = 3;
   localparam int POS_W  = 5;
   localparam int STAT_W = 2;

   typedef logic [ELEM_W-1:0] elem_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [IDX_W-1:0]  index_type;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT  = 3'd0,
      OP_DELETE  = 3'd1,
      OP_GET     = 3'd2,
      OP_FIND    = 3'd3,
      OP_REVERSE = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   // what one cell loads at the next edge
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOWER,
      CELL_UPPER,
      CELL_NEW,
      CELL_MIRROR
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      elem_type     data;
   } cell_ctrl_type;

endpackage

/* hdl/isa_cell.sv */
module isa_cell
   import isa_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  elem_type      lower_data,
   input  elem_type      upper_data,
   input  elem_type      mirror_data,
   output elem_type      data,
   output logic          match
);

   elem_type data_ff;
   elem_type data_in;

   // pick the source for this entry
   always_comb begin
      case (ctrl.cmd)
         CELL_LOWER:  data_in = lower_data;
         CELL_UPPER:  data_in = upper_data;
         CELL_NEW:    data_in = ctrl.data;
         CELL_MIRROR: data_in = mirror_data;
         default:     data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   // compare against the find key
   assign match = (data_ff == ctrl.data);

endmodule

/* hdl/indexed_shift_array.sv */
// Results are registered: for insert, delete, get and find, the result of an accepted item is
//   valid in the next cycle, and so is reverse on a list with fewer than two entries or a full list.
// Reverse otherwise runs one mirror step over all cells, then one cell-to-cell shift per empty
//   slot to pack the mirrored entries back down; its result is registered after the last shift.
// Throughput: one item per cycle; input is held while a reverse shifts or a result cannot drain.
// Reset: synchronous; clears the entry count, the controller and the result valid. Entries
//   are not cleared.
module indexed_shift_array
   import isa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [OP_W-1:0]   req_op,
   input  logic [POS_W-1:0]  req_position,
   input  logic [ELEM_W-1:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ELEM_W-1:0] rsp_read_value,
   output logic              rsp_found,
   output logic [IDX_W-1:0]  rsp_found_position,
   output logic [CNT_W-1:0]  rsp_length,
   output logic [STAT_W-1:0] rsp_status
);

   typedef enum logic {
      ST_IDLE,
      ST_SHIFT
   } state_type;

   state_type     state_ff, state_in;
   count_type     count_ff, count_in;
   count_type     shift_left_ff, shift_left_in;
   logic          rsp_valid_ff, rsp_valid_in;
   elem_type      rsp_read_value_ff, rsp_read_value_in;
   logic          rsp_found_ff, rsp_found_in;
   index_type     rsp_found_position_ff, rsp_found_position_in;
   count_type     rsp_length_ff, rsp_length_in;
   status_type    rsp_status_ff, rsp_status_in;

   logic          req_accept;
   logic          emit;
   cell_ctrl_type cell_ctrl [DEPTH];
   elem_type      cell_data [DEPTH];
   logic          cell_match [DEPTH];
   logic          hit_vec [DEPTH];
   logic          insert_ok, delete_ok, get_ok, reverse_long;
   logic          find_hit;
   index_type     find_pos;

   // hold input while shifting or while the result register cannot drain
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign insert_ok    = (count_ff < count_type'(DEPTH)) && (req_position <= count_ff);
   assign delete_ok    = req_position < count_ff;
   assign get_ok       = req_position < count_ff;
   assign reverse_long = (count_ff >= count_type'(2)) && (count_ff != count_type'(DEPTH));

   // row of cells, each linked to its neighbors and its mirror
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      isa_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[k]),
         .lower_data  ((k == 0) ? cell_data[0] : cell_data[(k == 0) ? 0 : k - 1]),
         .upper_data  (cell_data[(k == DEPTH - 1) ? k : k + 1]),
         .mirror_data (cell_data[DEPTH - 1 - k]),
         .data        (cell_data[k]),
         .match       (cell_match[k])
      );
      assign hit_vec[k] = cell_match[k] && (count_type'(k) < count_ff);
   end

   // per-cell commands
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         cell_ctrl[k].cmd  = CELL_HOLD;
         cell_ctrl[k].data = req_value;
         if (state_ff == ST_SHIFT) begin
            cell_ctrl[k].cmd = CELL_UPPER;
         end else if (req_accept) begin
            case (req_op)
               OP_INSERT: begin
                  if (insert_ok) begin
                     if (count_type'(k) == req_position) begin
                        cell_ctrl[k].cmd = CELL_NEW;
                     end else if ((count_type'(k) > req_position) &&
                                  (count_type'(k) <= count_ff)) begin
                        cell_ctrl[k].cmd = CELL_LOWER;
                     end
                  end
               end
               OP_DELETE: begin
                  if (delete_ok && (count_type'(k) >= req_position) &&
                      (count_type'(k + 1) < count_ff)) begin
                     cell_ctrl[k].cmd = CELL_UPPER;
                  end
               end
               OP_REVERSE: begin
                  if (count_ff >= count_type'(2)) begin
                     cell_ctrl[k].cmd = CELL_MIRROR;
                  end
               end
               default: cell_ctrl[k].cmd = CELL_HOLD;
            endcase
         end
      end
   end

   // lowest matching index
   always_comb begin
      find_hit = 1'b0;
      find_pos = '0;
      for (int k = DEPTH - 1; k >= 0; k--) begin
         if (hit_vec[k]) begin
            find_hit = 1'b1;
            find_pos = index_type'(k);
         end
      end
   end

   // next state, count and result
   always_comb begin
      state_in              = state_ff;
      count_in              = count_ff;
      shift_left_in         = shift_left_ff;
      emit                  = 1'b0;
      rsp_read_value_in     = rsp_read_value_ff;
      rsp_found_in          = rsp_found_ff;
      rsp_found_position_in = rsp_found_position_ff;
      rsp_length_in         = rsp_length_ff;
      rsp_status_in         = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               emit                  = 1'b1;
               rsp_read_value_in     = '0;
               rsp_found_in          = 1'b0;
               rsp_found_position_in = '0;
               rsp_status_in         = STAT_OK;
               case (req_op)
                  OP_INSERT: begin
                     if (count_ff >= count_type'(DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else if (!insert_ok) begin
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     if (delete_ok) begin
                        count_in = count_ff - 1'b1;
                     end else begin
                        rsp_status_in = STAT_RANGE;
                     end
                  end
                  OP_GET: begin
                     if (get_ok) begin
                        rsp_read_value_in = cell_data[req_position[IDX_W-1:0]];
                     end else begin
                        rsp_status_in = STAT_RANGE;
                     end
                  end
                  OP_FIND: begin
                     rsp_found_in          = find_hit;
                     rsp_found_position_in = find_pos;
                  end
                  OP_REVERSE: begin
                     if (reverse_long) begin
                        emit          = 1'b0;
                        state_in      = ST_SHIFT;
                        shift_left_in = count_type'(DEPTH) - count_ff;
                     end
                  end
                  default: rsp_status_in = STAT_OK;
               endcase
               rsp_length_in = count_in;
            end
         end
         ST_SHIFT: begin
            shift_left_in = shift_left_ff - 1'b1;
            if (shift_left_ff == count_type'(1)) begin
               state_in      = ST_IDLE;
               emit          = 1'b1;
               rsp_length_in = count_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   // hold state and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         shift_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         shift_left_ff <= shift_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_read_value_ff     <= rsp_read_value_in;
      rsp_found_ff          <= rsp_found_in;
      rsp_found_position_ff <= rsp_found_position_in;
      rsp_length_ff         <= rsp_length_in;
      rsp_status_ff         <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_read_value_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_found_position_ff;
   assign rsp_length         = rsp_length_ff;
   assign rsp_status         = rsp_status_ff;

   // no result may be pending while the shift runs
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> !rsp_valid_ff)
      else $error("result pending during reverse shift");

   // a waiting result reports the current count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_length_ff == count_ff))
      else $error("result length differs from entry count");

   // a legal insert grows the list by one
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == OP_INSERT) && insert_ok)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the list");

endmodule
